// ----- design/lav_pkg.sv -----
// ---------------------------------------------------------------------------
// lav_pkg
// Shared constants of the camera view matrix pipeline.
// ---------------------------------------------------------------------------
package lav_pkg;

  localparam int COORD_W       = 32;   // input coordinate and translation width
  localparam int FRAC_BITS_DEF = 16;   // default fraction bits (Q16.16)
  localparam int NORM_MSB      = 30;   // the largest scaled magnitude lands in [2^30, 2^31)
  localparam int MAG_W         = 31;   // width of a scaled magnitude
  localparam int SUM_W         = 64;   // sum of three squared magnitudes
  localparam int ROOT_W        = 32;   // integer root of that sum
  localparam int SQRT_STEPS    = 32;   // one result bit per stage
  localparam int NORM_LAT_BASE = 40;   // length of the normaliser's valid line, less FRAC_BITS

  localparam logic [COORD_W-1:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

// ----- design/look_at_view_matrix.sv -----
// ---------------------------------------------------------------------------
// look_at_view_matrix
// Camera view matrix from eye, target and up: basis rows and translation.
// ---------------------------------------------------------------------------
// Channel  Direction  Handshake                  Payload
// request  in         in_valid_i / in_ready_o    eye, target, up (Q16.16)
// result   out        out_valid_o / out_ready_i  right, upward, back, shifts
//
// One request per cycle while in_ready_o is high (FRAC_BITS = 16 gives Q16.16).
// The pipeline is built from two normalisers, each a 32-stage square root and a
// FRAC_BITS+1 stage divider, plus the product and sum stages between them.
// Reset clears all valid bits; the datapath registers are not reset.
// A stalled result moves into a skid register; in_ready_o drops only while
// that skid register is full, and then the whole pipeline holds.
// ---------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [COORD_W-1:0]   eye_x_i,
  input  logic signed [COORD_W-1:0]   eye_y_i,
  input  logic signed [COORD_W-1:0]   eye_z_i,
  input  logic signed [COORD_W-1:0]   target_x_i,
  input  logic signed [COORD_W-1:0]   target_y_i,
  input  logic signed [COORD_W-1:0]   target_z_i,
  input  logic signed [COORD_W-1:0]   up_x_i,
  input  logic signed [COORD_W-1:0]   up_y_i,
  input  logic signed [COORD_W-1:0]   up_z_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [FRAC_BITS+1:0] right_x_o,
  output logic signed [FRAC_BITS+1:0] right_y_o,
  output logic signed [FRAC_BITS+1:0] right_z_o,
  output logic signed [FRAC_BITS+1:0] upward_x_o,
  output logic signed [FRAC_BITS+1:0] upward_y_o,
  output logic signed [FRAC_BITS+1:0] upward_z_o,
  output logic signed [FRAC_BITS+1:0] back_x_o,
  output logic signed [FRAC_BITS+1:0] back_y_o,
  output logic signed [FRAC_BITS+1:0] back_z_o,
  output logic signed [COORD_W-1:0]   shift_right_o,
  output logic signed [COORD_W-1:0]   shift_up_o,
  output logic signed [COORD_W-1:0]   shift_forward_o
);

  localparam int FW    = FRAC_BITS + 2;      // unit component
  localparam int DIF_W = COORD_W + 1;        // target minus eye
  localparam int PF_W  = FW + COORD_W;       // unit times coordinate
  localparam int CW    = FW + COORD_W + 1;   // cross of forward and up
  localparam int DOT_W = FW + COORD_W + 2;   // exact sums before rounding
  localparam int SIDE1 = 6 * COORD_W;
  localparam int SIDE2 = 3 * COORD_W + 3 * FW;
  localparam logic [DOT_W-1:0]        HALF_FX = DOT_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DOT_W-1:0] ONE_D   = DOT_W'(1) << FRAC_BITS;

  function automatic logic signed [DOT_W-1:0] rescale(input logic signed [DOT_W-1:0] x);
    logic [DOT_W-1:0] m;
    logic [DOT_W-1:0] q;
    m = x[DOT_W-1] ? DOT_W'(-x) : DOT_W'(x);
    q = (m + HALF_FX) >> FRAC_BITS;
    return x[DOT_W-1] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [COORD_W-1:0] sat32(input logic signed [DOT_W-1:0] x);
    if (x[DOT_W-1:COORD_W-1] == '0 || x[DOT_W-1:COORD_W-1] == '1) begin
      return x[COORD_W-1:0];
    end
    return x[DOT_W-1] ? SAT_NEG : SAT_POS;
  endfunction

  function automatic logic signed [FW-1:0] clamp_one(input logic signed [DOT_W-1:0] x);
    if (x > ONE_D) return FW'(ONE_D);
    if (x < -ONE_D) return FW'(-ONE_D);
    return FW'(x);
  endfunction

  logic en;
  logic skid_vld_q;
  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  // valid bits of the stages outside the normalisers
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic n1_vld, n2_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q} <= '0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= n1_vld;
      v3_q <= v2_q;
      v4_q <= n2_vld;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  // stage 0 and 1: capture, difference
  logic signed [COORD_W-1:0] eye0_q [3];
  logic signed [COORD_W-1:0] tgt0_q [3];
  logic signed [COORD_W-1:0] up0_q [3];
  logic signed [DIF_W-1:0]   d1_q [3];
  logic [SIDE1-1:0]          side1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      eye0_q <= '{eye_x_i, eye_y_i, eye_z_i};
      tgt0_q <= '{target_x_i, target_y_i, target_z_i};
      up0_q  <= '{up_x_i, up_y_i, up_z_i};
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= DIF_W'(tgt0_q[i]) - DIF_W'(eye0_q[i]);
        side1_q[COORD_W*i +: COORD_W]     <= eye0_q[i];
        side1_q[COORD_W*(3+i) +: COORD_W] <= up0_q[i];
      end
    end
  end

  logic signed [FW-1:0] f_n [3];
  logic [SIDE1-1:0]     side_n1;

  lav_norm #(
    .IN_W     (DIF_W),
    .FRAC_BITS(FRAC_BITS),
    .SIDE_W   (SIDE1)
  ) u_norm_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v1_q),
    .vec_i  (d1_q),
    .side_i (side1_q),
    .valid_o(n1_vld),
    .vec_o  (f_n),
    .side_o (side_n1)
  );

  // stage 2 and 3: cross of forward and up
  logic signed [COORD_W-1:0] upn [3];
  logic signed [COORD_W-1:0] eyen [3];
  logic signed [PF_W-1:0]    pf2_q [6];
  logic signed [FW-1:0]      f2_q [3];
  logic signed [COORD_W-1:0] eye2_q [3];
  logic signed [CW-1:0]      c3_q [3];
  logic [SIDE2-1:0]          side3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eyen[i] = $signed(side_n1[COORD_W*i +: COORD_W]);
      upn[i]  = $signed(side_n1[COORD_W*(3+i) +: COORD_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pf2_q[0] <= f_n[1] * upn[2];
      pf2_q[1] <= f_n[2] * upn[1];
      pf2_q[2] <= f_n[2] * upn[0];
      pf2_q[3] <= f_n[0] * upn[2];
      pf2_q[4] <= f_n[0] * upn[1];
      pf2_q[5] <= f_n[1] * upn[0];
      f2_q     <= f_n;
      eye2_q   <= eyen;
      for (int i = 0; i < 3; i++) begin
        c3_q[i] <= CW'(pf2_q[2*i]) - CW'(pf2_q[2*i+1]);
        side3_q[COORD_W*i +: COORD_W]  <= eye2_q[i];
        side3_q[3*COORD_W + FW*i +: FW] <= f2_q[i];
      end
    end
  end

  logic signed [FW-1:0] r_n [3];
  logic [SIDE2-1:0]     side_n2;

  lav_norm #(
    .IN_W     (CW),
    .FRAC_BITS(FRAC_BITS),
    .SIDE_W   (SIDE2)
  ) u_norm_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v3_q),
    .vec_i  (c3_q),
    .side_i (side3_q),
    .valid_o(n2_vld),
    .vec_o  (r_n),
    .side_o (side_n2)
  );

  // stages 4 to 9: true up and translation terms
  logic signed [COORD_W-1:0] eyem [3];
  logic signed [FW-1:0]      fm [3];
  logic signed [2*FW-1:0]    ru4_q [6];
  logic signed [PF_W-1:0]    re4_q [3];
  logic signed [PF_W-1:0]    fe4_q [3];
  logic signed [FW-1:0]      r4_q [3], r5_q [3], r6_q [3], r7_q [3], r8_q [3];
  logic signed [FW-1:0]      f4_q [3], f5_q [3], f6_q [3], f7_q [3], f8_q [3];
  logic signed [COORD_W-1:0] eye4_q [3], eye5_q [3], eye6_q [3];
  logic signed [DOT_W-1:0]   ud5_q [3];
  logic signed [DOT_W-1:0]   tr5_q, tf5_q;
  logic signed [FW-1:0]      u6_q [3], u7_q [3], u8_q [3];
  logic [COORD_W-1:0]        tr6_q, tf6_q, tr7_q, tf7_q, tr8_q, tf8_q;
  logic signed [PF_W-1:0]    ue7_q [3];
  logic signed [DOT_W-1:0]   tu8_q;
  logic signed [FW-1:0]      vec9_q [9];
  logic [COORD_W-1:0]        sh9_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eyem[i] = $signed(side_n2[COORD_W*i +: COORD_W]);
      fm[i]   = $signed(side_n2[3*COORD_W + FW*i +: FW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ru4_q[0] <= r_n[1] * fm[2];
      ru4_q[1] <= r_n[2] * fm[1];
      ru4_q[2] <= r_n[2] * fm[0];
      ru4_q[3] <= r_n[0] * fm[2];
      ru4_q[4] <= r_n[0] * fm[1];
      ru4_q[5] <= r_n[1] * fm[0];
      for (int i = 0; i < 3; i++) begin
        re4_q[i] <= r_n[i] * eyem[i];
        fe4_q[i] <= fm[i] * eyem[i];
        ud5_q[i] <= DOT_W'(ru4_q[2*i]) - DOT_W'(ru4_q[2*i+1]);
        u6_q[i]  <= clamp_one(rescale(ud5_q[i]));
        ue7_q[i] <= u6_q[i] * eye6_q[i];
      end
      tr5_q <= DOT_W'(re4_q[0]) + DOT_W'(re4_q[1]) + DOT_W'(re4_q[2]);
      tf5_q <= DOT_W'(fe4_q[0]) + DOT_W'(fe4_q[1]) + DOT_W'(fe4_q[2]);
      tr6_q <= sat32(-rescale(tr5_q));
      tf6_q <= sat32(rescale(tf5_q));
      tu8_q <= DOT_W'(ue7_q[0]) + DOT_W'(ue7_q[1]) + DOT_W'(ue7_q[2]);
      // hold the other results alongside
      r4_q <= r_n;   r5_q <= r4_q;  r6_q <= r5_q;  r7_q <= r6_q;  r8_q <= r7_q;
      f4_q <= fm;    f5_q <= f4_q;  f6_q <= f5_q;  f7_q <= f6_q;  f8_q <= f7_q;
      eye4_q <= eyem; eye5_q <= eye4_q; eye6_q <= eye5_q;
      u7_q  <= u6_q;  u8_q  <= u7_q;
      tr7_q <= tr6_q; tr8_q <= tr7_q;
      tf7_q <= tf6_q; tf8_q <= tf7_q;
      for (int i = 0; i < 3; i++) begin
        vec9_q[i]   <= r8_q[i];
        vec9_q[3+i] <= u8_q[i];
        vec9_q[6+i] <= -f8_q[i];
      end
      sh9_q[0] <= tr8_q;
      sh9_q[1] <= sat32(-rescale(tu8_q));
      sh9_q[2] <= tf8_q;
    end
  end

  // output register with skid stage
  logic                 out_vld_q;
  logic signed [FW-1:0] out_vec_q [9];
  logic [COORD_W-1:0]   out_sh_q [3];
  logic signed [FW-1:0] skid_vec_q [9];
  logic [COORD_W-1:0]   skid_sh_q [3];
  logic                 out_fire;

  assign out_fire = out_vld_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) skid_vld_q <= 1'b0;
    end else if (v9_q) begin
      if (!out_vld_q || out_fire) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_vec_q <= skid_vec_q;
        out_sh_q  <= skid_sh_q;
      end
    end else if (v9_q) begin
      if (!out_vld_q || out_fire) begin
        out_vec_q <= vec9_q;
        out_sh_q  <= sh9_q;
      end else begin
        skid_vec_q <= vec9_q;
        skid_sh_q  <= sh9_q;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign right_x_o       = out_vec_q[0];
  assign right_y_o       = out_vec_q[1];
  assign right_z_o       = out_vec_q[2];
  assign upward_x_o      = out_vec_q[3];
  assign upward_y_o      = out_vec_q[4];
  assign upward_z_o      = out_vec_q[5];
  assign back_x_o        = out_vec_q[6];
  assign back_y_o        = out_vec_q[7];
  assign back_z_o        = out_vec_q[8];
  assign shift_right_o   = out_sh_q[0];
  assign shift_up_o      = out_sh_q[1];
  assign shift_forward_o = out_sh_q[2];

endmodule

// ----- design/lav_norm.sv -----
// ---------------------------------------------------------------------------
// lav_norm
// Pipelined three-component normaliser: scale, square, root, divide.
// ---------------------------------------------------------------------------
module lav_norm import lav_pkg::*; #(
  parameter int IN_W      = 33,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [IN_W-1:0]      vec_i [3],
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic signed [FRAC_BITS+1:0] vec_o [3],
  output logic [SIDE_W-1:0]           side_o
);

  localparam int PW  = $clog2(IN_W);
  localparam int QW  = FRAC_BITS + 1;
  localparam int DW  = FRAC_BITS + 33;
  localparam int OW  = FRAC_BITS + 2;
  localparam int LAT = FRAC_BITS + NORM_LAT_BASE;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  // valid and sideband shift line
  logic [LAT-1:0]    vld_q;
  logic [SIDE_W-1:0] side_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int i = 1; i < LAT; i++) side_q[i] <= side_q[i-1];
    end
  end

  assign valid_o = vld_q[LAT-1];
  assign side_o  = side_q[LAT-1];

  // stage A: magnitudes
  logic [IN_W-1:0] mag_a_q [3];
  logic [2:0]      neg_a_q;
  // stage B: leading one of the largest magnitude
  logic [IN_W-1:0] mag_b_q [3];
  logic [2:0]      neg_b_q;
  logic [PW-1:0]   pos_b_q;
  logic            zero_b_q;
  logic [IN_W-1:0] or_w;
  logic [PW-1:0]   pos_d;
  // stage C: scaled magnitudes
  logic [MAG_W-1:0] mag_c_d [3];
  logic [MAG_W-1:0] mag_c_q [3];
  logic [2:0]       neg_c_q;
  logic             zero_c_q;
  // stage D: squares
  logic [2*MAG_W-1:0] sq_d_q [3];
  logic [MAG_W-1:0]   mag_d_q [3];
  logic [2:0]         neg_d_q;
  logic               zero_d_q;
  // stage E: sum of squares
  logic [SUM_W-1:0] s_e_q;
  logic [MAG_W-1:0] mag_e_q [3];
  logic [2:0]       neg_e_q;
  logic             zero_e_q;

  always_comb begin
    or_w  = mag_a_q[0] | mag_a_q[1] | mag_a_q[2];
    pos_d = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (or_w[b]) pos_d = PW'(b);
    end
  end

  always_comb begin
    logic [IN_W-1:0] shf;
    for (int l = 0; l < 3; l++) begin
      if (pos_b_q > PW'(NORM_MSB)) begin
        shf = mag_b_q[l] >> (pos_b_q - PW'(NORM_MSB));
      end else begin
        shf = mag_b_q[l] << (PW'(NORM_MSB) - pos_b_q);
      end
      mag_c_d[l] = shf[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        neg_a_q[l] <= vec_i[l][IN_W-1];
        mag_a_q[l] <= vec_i[l][IN_W-1] ? IN_W'(-vec_i[l]) : IN_W'(vec_i[l]);
        mag_b_q[l] <= mag_a_q[l];
        mag_c_q[l] <= mag_c_d[l];
        sq_d_q[l]  <= mag_c_q[l] * mag_c_q[l];
        mag_d_q[l] <= mag_c_q[l];
        mag_e_q[l] <= mag_d_q[l];
      end
      neg_b_q  <= neg_a_q;
      pos_b_q  <= pos_d;
      zero_b_q <= (or_w == '0);
      neg_c_q  <= neg_b_q;
      zero_c_q <= zero_b_q;
      neg_d_q  <= neg_c_q;
      zero_d_q <= zero_c_q;
      s_e_q    <= SUM_W'(sq_d_q[0]) + SUM_W'(sq_d_q[1]) + SUM_W'(sq_d_q[2]);
      neg_e_q  <= neg_d_q;
      zero_e_q <= zero_d_q;
    end
  end

  // square root, one result bit per stage
  logic [SUM_W-1:0] n_src [SQRT_STEPS];
  logic [SUM_W-1:0] res_src [SQRT_STEPS];
  logic [SUM_W-1:0] n_d [SQRT_STEPS];
  logic [SUM_W-1:0] res_d [SQRT_STEPS];
  logic [SUM_W-1:0] n_q [SQRT_STEPS];
  logic [SUM_W-1:0] res_q [SQRT_STEPS];
  logic [MAG_W-1:0] mag_s_q [SQRT_STEPS][3];
  logic [2:0]       neg_s_q [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] zero_s_q;

  always_comb begin
    logic [SUM_W-1:0] bitv;
    logic [SUM_W:0]   t;
    n_src[0]   = s_e_q;
    res_src[0] = '0;
    for (int j = 1; j < SQRT_STEPS; j++) begin
      n_src[j]   = n_q[j-1];
      res_src[j] = res_q[j-1];
    end
    for (int j = 0; j < SQRT_STEPS; j++) begin
      bitv = SUM_W'(1) << (SUM_W - 2 - 2 * j);
      t    = {1'b0, res_src[j]} + {1'b0, bitv};
      if ({1'b0, n_src[j]} >= t) begin
        n_d[j]   = n_src[j] - t[SUM_W-1:0];
        res_d[j] = (res_src[j] >> 1) + bitv;
      end else begin
        n_d[j]   = n_src[j];
        res_d[j] = res_src[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < SQRT_STEPS; j++) begin
        n_q[j]   <= n_d[j];
        res_q[j] <= res_d[j];
      end
      mag_s_q[0]  <= mag_e_q;
      neg_s_q[0]  <= neg_e_q;
      zero_s_q[0] <= zero_e_q;
      for (int j = 1; j < SQRT_STEPS; j++) begin
        mag_s_q[j]  <= mag_s_q[j-1];
        neg_s_q[j]  <= neg_s_q[j-1];
        zero_s_q[j] <= zero_s_q[j-1];
      end
    end
  end

  // divide set-up: numerator with half the root added for rounding
  logic [ROOT_W-1:0] root;
  logic [DW-1:0]     rem0_q [3];
  logic [ROOT_W-1:0] r0_q;
  logic [2:0]        neg0_q;
  logic              zero0_q;

  assign root = res_q[SQRT_STEPS-1][ROOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        rem0_q[l] <= (DW'(mag_s_q[SQRT_STEPS-1][l]) << FRAC_BITS) + DW'(root >> 1);
      end
      r0_q    <= root;
      neg0_q  <= neg_s_q[SQRT_STEPS-1];
      zero0_q <= zero_s_q[SQRT_STEPS-1];
    end
  end

  // restoring division, one quotient bit per stage, three lanes
  logic [DW-1:0]     rem_src [QW][3];
  logic [QW-1:0]     q_src [QW][3];
  logic [ROOT_W-1:0] r_src [QW];
  logic [DW-1:0]     rem_d [QW][3];
  logic [QW-1:0]     q_d [QW][3];
  logic [DW-1:0]     rem_q [QW][3];
  logic [QW-1:0]     q_q [QW][3];
  logic [ROOT_W-1:0] r_q [QW];
  logic [2:0]        neg_v_q [QW];
  logic [QW-1:0]     zero_v_q;

  always_comb begin
    logic [DW-1:0] den;
    for (int l = 0; l < 3; l++) begin
      rem_src[0][l] = rem0_q[l];
      q_src[0][l]   = '0;
    end
    r_src[0] = r0_q;
    for (int i = 1; i < QW; i++) begin
      rem_src[i] = rem_q[i-1];
      q_src[i]   = q_q[i-1];
      r_src[i]   = r_q[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      den = DW'(r_src[i]) << (FRAC_BITS - i);
      for (int l = 0; l < 3; l++) begin
        if (rem_src[i][l] >= den) begin
          rem_d[i][l] = rem_src[i][l] - den;
          q_d[i][l]   = q_src[i][l] | (QW'(1) << (FRAC_BITS - i));
        end else begin
          rem_d[i][l] = rem_src[i][l];
          q_d[i][l]   = q_src[i][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QW; i++) begin
        rem_q[i] <= rem_d[i];
        q_q[i]   <= q_d[i];
        r_q[i]   <= r_src[i];
      end
      neg_v_q[0]  <= neg0_q;
      zero_v_q[0] <= zero0_q;
      for (int i = 1; i < QW; i++) begin
        neg_v_q[i]  <= neg_v_q[i-1];
        zero_v_q[i] <= zero_v_q[i-1];
      end
    end
  end

  // clamp, restore sign, force zero-length vectors to zero
  logic signed [OW-1:0] out_q [3];

  always_ff @(posedge clk_i) begin
    logic [QW-1:0] qc;
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        qc = (q_q[QW-1][l] > ONE_Q) ? ONE_Q : q_q[QW-1][l];
        if (zero_v_q[QW-1]) begin
          out_q[l] <= '0;
        end else if (neg_v_q[QW-1][l]) begin
          out_q[l] <= -OW'(qc);
        end else begin
          out_q[l] <= OW'(qc);
        end
      end
    end
  end

  assign vec_o = out_q;

endmodule

// ----- design/lav_chk.sv -----
// ---------------------------------------------------------------------------
// lav_chk
// Port-level checks on the view matrix block, bound to its top level.
// ---------------------------------------------------------------------------
module lav_chk import lav_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic signed [FRAC_BITS+1:0] right_x_o,
  input logic signed [FRAC_BITS+1:0] upward_y_o,
  input logic signed [FRAC_BITS+1:0] back_z_o,
  input logic signed [COORD_W-1:0]   shift_up_o
);

  localparam logic signed [FRAC_BITS+1:0] ONE = (FRAC_BITS + 2)'(1) << FRAC_BITS;

  // a result waits until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(shift_up_o))
    else $error("stalled result changed");

  // requests are refused only after a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // right_x, upward_y and back_z never exceed one in magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> right_x_o <= ONE && right_x_o >= -ONE && upward_y_o <= ONE
                    && upward_y_o >= -ONE && back_z_o <= ONE && back_z_o >= -ONE)
    else $error("unit component out of range");

endmodule

bind look_at_view_matrix lav_chk #(.FRAC_BITS(FRAC_BITS)) u_lav_chk (.*);

// ----- sim/lav_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lav_result_checker
// Watches both channels of the view matrix block, predicts each result from
// the accepted request and compares it field by field, oldest first.
// ----------------------------------------------------------------------------
module lav_result_checker import lav_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [COORD_W-1:0] eye_x_i,
  input  logic signed [COORD_W-1:0] eye_y_i,
  input  logic signed [COORD_W-1:0] eye_z_i,
  input  logic signed [COORD_W-1:0] target_x_i,
  input  logic signed [COORD_W-1:0] target_y_i,
  input  logic signed [COORD_W-1:0] target_z_i,
  input  logic signed [COORD_W-1:0] up_x_i,
  input  logic signed [COORD_W-1:0] up_y_i,
  input  logic signed [COORD_W-1:0] up_z_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [17:0]               right_x_i,
  input  logic [17:0]               right_y_i,
  input  logic [17:0]               right_z_i,
  input  logic [17:0]               upward_x_i,
  input  logic [17:0]               upward_y_i,
  input  logic [17:0]               upward_z_i,
  input  logic [17:0]               back_x_i,
  input  logic [17:0]               back_y_i,
  input  logic [17:0]               back_z_i,
  input  logic [COORD_W-1:0]        shift_right_i,
  input  logic [COORD_W-1:0]        shift_up_i,
  input  logic [COORD_W-1:0]        shift_forward_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        matrices_o
);

  localparam int FB = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;

  typedef struct packed {
    logic [17:0] rx, ry, rz, ux, uy, uz, bx, by, bz;
    logic [COORD_W-1:0] tr, tu, tf;
  } view_t;

  view_t view_q[$];

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void unit_vec(input longint v[3], output longint o[3]);
    longint unsigned m[3], mx, s, r, q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = root64(s);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FB) + (r >> 1)) / r;
      if (q > ONE) q = ONE;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  // drop FB fraction bits, rounding half away from zero
  function automatic longint round_fx(longint x);
    longint unsigned q;
    q = ((x < 0 ? -x : x) + (64'd1 << (FB - 1))) >> FB;
    return x < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [COORD_W-1:0] sat_fx(longint x);
    if (x > 64'sd2147483647) return SAT_POS;
    if (x < -64'sd2147483648) return SAT_NEG;
    return x[COORD_W-1:0];
  endfunction

  function automatic longint clamp_fx(longint x);
    return x > ONE ? ONE : (x < -ONE ? -ONE : x);
  endfunction

  function automatic view_t build_view(longint eye[3], longint tgt[3], longint upd[3]);
    longint d[3], f[3], c[3], r[3], u[3];
    view_t v;
    for (int i = 0; i < 3; i++) d[i] = tgt[i] - eye[i];
    unit_vec(d, f);
    c[0] = f[1] * upd[2] - f[2] * upd[1];
    c[1] = f[2] * upd[0] - f[0] * upd[2];
    c[2] = f[0] * upd[1] - f[1] * upd[0];
    unit_vec(c, r);
    u[0] = clamp_fx(round_fx(r[1] * f[2] - r[2] * f[1]));
    u[1] = clamp_fx(round_fx(r[2] * f[0] - r[0] * f[2]));
    u[2] = clamp_fx(round_fx(r[0] * f[1] - r[1] * f[0]));
    v.rx = r[0][17:0]; v.ry = r[1][17:0]; v.rz = r[2][17:0];
    v.ux = u[0][17:0]; v.uy = u[1][17:0]; v.uz = u[2][17:0];
    v.bx = 18'(-f[0]); v.by = 18'(-f[1]); v.bz = 18'(-f[2]);
    v.tr = sat_fx(-round_fx(r[0] * eye[0] + r[1] * eye[1] + r[2] * eye[2]));
    v.tu = sat_fx(-round_fx(u[0] * eye[0] + u[1] * eye[1] + u[2] * eye[2]));
    v.tf = sat_fx(round_fx(f[0] * eye[0] + f[1] * eye[1] + f[2] * eye[2]));
    return v;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    fail_count_o++;
    $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  initial begin
    fail_count_o = 0;
    matrices_o   = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    view_t want;
    if (rst_ni && in_valid_i && in_ready_i)
      view_q.push_back(build_view('{eye_x_i, eye_y_i, eye_z_i},
                                  '{target_x_i, target_y_i, target_z_i},
                                  '{up_x_i, up_y_i, up_z_i}));
    if (rst_ni && out_valid_i && out_ready_i) begin
      matrices_o++;
      if (view_q.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        want = view_q.pop_front();
        if (right_x_i  !== want.rx) report("right_x",  32'(right_x_i),  32'(want.rx));
        if (right_y_i  !== want.ry) report("right_y",  32'(right_y_i),  32'(want.ry));
        if (right_z_i  !== want.rz) report("right_z",  32'(right_z_i),  32'(want.rz));
        if (upward_x_i !== want.ux) report("upward_x", 32'(upward_x_i), 32'(want.ux));
        if (upward_y_i !== want.uy) report("upward_y", 32'(upward_y_i), 32'(want.uy));
        if (upward_z_i !== want.uz) report("upward_z", 32'(upward_z_i), 32'(want.uz));
        if (back_x_i   !== want.bx) report("back_x",   32'(back_x_i),   32'(want.bx));
        if (back_y_i   !== want.by) report("back_y",   32'(back_y_i),   32'(want.by));
        if (back_z_i   !== want.bz) report("back_z",   32'(back_z_i),   32'(want.bz));
        if (shift_right_i   !== want.tr) report("shift_right",   shift_right_i,   want.tr);
        if (shift_up_i      !== want.tu) report("shift_up",      shift_up_i,      want.tu);
        if (shift_forward_i !== want.tf) report("shift_forward", shift_forward_i, want.tf);
      end
    end
    pending_o = view_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed camera set-ups and then random bursts into the view matrix
// block, with a stalling receiver and one long hold-off, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import lav_pkg::*;

  localparam int NUM_RANDOM = 930;
  localparam int LATENCY    = 2 * FRAC_BITS_DEF + 91;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_START = 800;
  localparam int HOLD_LEN   = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [COORD_W-1:0] eye_x_i = '0, eye_y_i = '0, eye_z_i = '0;
  logic signed [COORD_W-1:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic signed [COORD_W-1:0] up_x_i = '0, up_y_i = '0, up_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [FRAC_BITS_DEF+1:0] right_x_o, right_y_o, right_z_o;
  logic signed [FRAC_BITS_DEF+1:0] upward_x_o, upward_y_o, upward_z_o;
  logic signed [FRAC_BITS_DEF+1:0] back_x_o, back_y_o, back_z_o;
  logic signed [COORD_W-1:0] shift_right_o, shift_up_o, shift_forward_o;

  int fail_count, pending, matrices;
  int requests_sent = 0;
  int idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  look_at_view_matrix dut (.*);

  lav_result_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .eye_x_i, .eye_y_i, .eye_z_i, .target_x_i, .target_y_i, .target_z_i,
    .up_x_i, .up_y_i, .up_z_i, .out_valid_i(out_valid_o), .out_ready_i,
    .right_x_i(right_x_o), .right_y_i(right_y_o), .right_z_i(right_z_o),
    .upward_x_i(upward_x_o), .upward_y_i(upward_y_o), .upward_z_i(upward_z_o),
    .back_x_i(back_x_o), .back_y_i(back_y_o), .back_z_i(back_z_o),
    .shift_right_i(shift_right_o), .shift_up_i(shift_up_o),
    .shift_forward_i(shift_forward_o),
    .fail_count_o(fail_count), .pending_o(pending), .matrices_o(matrices)
  );

  // watchdog: count cycles with no request and no result accepted
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("** look_at_view_matrix: FAILED **");
        $finish;
      end
    end
  end

  // receiver: random stall patterns, each held for a random stretch, one long hold-off
  initial begin
    int mode, left, ticks;
    mode  = 0;
    left  = 0;
    ticks = 0;
    forever begin
      @(negedge clk_i);
      ticks++;
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      if (ticks >= HOLD_START && ticks < HOLD_START + HOLD_LEN)
        out_ready_i <= 1'b0;
      else case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2: out_ready_i <= ($urandom_range(0, 1) != 0);
        default: out_ready_i <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      default: return $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
    endcase
  endfunction

  // hold valid until accepted; payload stays put meanwhile
  task automatic send_setup(logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    eye_x_i <= ex; eye_y_i <= ey; eye_z_i <= ez;
    target_x_i <= tx; target_y_i <= ty; target_z_i <= tz;
    up_x_i <= ux; up_y_i <= uy; up_z_i <= uz;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
    @(negedge clk_i);
  endtask

  localparam logic [31:0] P1 = 32'h0001_0000;
  localparam logic [31:0] M1 = 32'hffff_0000;
  localparam logic [31:0] MX = 32'h7fff_ffff;
  localparam logic [31:0] MN = 32'h8000_0000;

  initial begin
    int burst, gap;
    logic [31:0] ex, ey, ez, tx, ty, tz;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // plain cameras with y up, the first looking down -z
    send_setup(0, 0, 5 * P1, 0, 0, 0, 0, P1, 0);
    send_setup(3 * P1, 2 * P1, 7 * P1, M1, P1, 0, 0, P1, 0);
    // eye on target
    send_setup(P1, P1, P1, P1, P1, P1, 0, P1, 0);
    send_setup(MN, MX, 0, MN, MX, 0, MX, MX, MX);
    // up zero, then up parallel to forward
    send_setup(0, 0, 0, P1, 0, 0, 0, 0, 0);
    send_setup(0, 0, 0, 0, 2 * P1, 0, 0, 3 * P1, 0);
    send_setup(P1, P1, P1, 0, 0, 0, M1, M1, M1);
    // extremes: differences that overflow 32 bits, saturating shifts
    send_setup(MN, MN, MN, MX, MX, MX, MN, MX, MN);
    send_setup(MX, MX, MX, MN, MN, MN, MX, MN, MX);
    send_setup(MX, MN, MX, 0, 0, 0, 0, MX, 0);
    send_setup(MN, MX, MN, MX, MN, MX, MX, 0, MN);
    send_setup(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 1, 1, 0, 0);
    send_setup(1, 0, 0, 0, 1, 0, 0, 0, 1);
    send_setup(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
               32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333, 32'hcccc_cccc, 1);
    send_setup(MX, MX, MX, MX, MX, MN, P1, 0, 0);
    in_valid_i <= 1'b0;
    @(negedge clk_i);

    for (int n = 0; n < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++) begin
        ex = rand_coord(); ey = rand_coord(); ez = rand_coord();
        case ($urandom_range(0, 19))
          0: begin tx = ex; ty = ey; tz = ez; end
          1: begin tx = ex; ty = ey + rand_coord(); tz = ez; end
          default: begin tx = rand_coord(); ty = rand_coord(); tz = rand_coord(); end
        endcase
        case ($urandom_range(0, 19))
          0: send_setup(ex, ey, ez, tx, ty, tz, 0, 0, 0);
          1: send_setup(ex, ey, ez, tx, ty, tz, tx - ex, ty - ey, tz - ez);
          default: send_setup(ex, ey, ez, tx, ty, tz,
                              rand_coord(), rand_coord(), rand_coord());
        endcase
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("sent %0d camera set-ups (directed and random, including a long",
             requests_sent);
    $display("output hold-off); %0d view matrices checked", matrices);
    if (fail_count == 0 && pending == 0) begin
      $display("** look_at_view_matrix: PASSED **");
    end else begin
      $display("** look_at_view_matrix: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lav_pkg.sv
design/lav_norm.sv
design/look_at_view_matrix.sv
design/lav_chk.sv
sim/lav_result_checker.sv
sim/tb_top.sv
